// ===== hdl/bhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bhpq_pkg
// Types, codes and defaults shared by the binary heap priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  localparam int unsigned CapacityDef = 255;
  localparam int unsigned KeyWidthDef = 32;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 8;

  typedef enum logic [FuncW-1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_DEL_TOP = 2'd1,
    FUNC_DEL_KEY = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SU_RD,
    ST_SU_CMP,
    ST_DT_RD,
    ST_DT_TAKE,
    ST_SR_RD,
    ST_SR_CMP,
    ST_RM_LAST,
    ST_RM_LASTD,
    ST_RM_PAR,
    ST_SD_RD,
    ST_SD_C1,
    ST_SD_C2,
    ST_SD_DEC,
    ST_DONE
  } state_e;

  // true when key a belongs above key b; keys come sign-extended to 64 bits
  function automatic logic ranks_above(input logic signed [63:0] a,
                                       input logic signed [63:0] b,
                                       input logic               max_mode);
    ranks_above = max_mode ? (a > b) : (a < b);
  endfunction

endpackage

// ===== hdl/binary_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Array-based binary heap of signed keys in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage: each item on the slave stream carries an operation in tuser
// (insert, delete top, delete matching key) and a key in tdata. Each item
// gives exactly one result item on the master stream: the removed key, a
// status code and the number of keys held afterwards.
// cfg_we_i/cfg_wdata_i set the order: 0 smallest key on top, 1 largest.
// Write it only while the block is idle.
// One item is worked at a time; s_axis_tready is high only while idle.
// Every step goes through the single memory read port, read data registered.
// Insert moves the new key up one level at a time. Delete top takes the
// root and moves the last key into its place, then down level by level.
// Delete by key searches the entries one after another from the root slot,
// then removes the match the same way, moving the last key up or down.
// Full and empty errors give their result item without touching the memory.
// The next item is accepted from the cycle its result item appears.
// Results sit in an output register; a stalled master side holds the
// result and the block waits in its final state until the register frees.
// Reset empties the heap and selects min order; the memory is not cleared.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue #(
  parameter int unsigned CAPACITY  = bhpq_pkg::CapacityDef,
  parameter int unsigned KEY_WIDTH = bhpq_pkg::KeyWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] key
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] out_key, [39:32] count
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned AddrW = $clog2(CAPACITY + 1);

  bhpq_pkg::state_e state_q, state_d;

  logic [KEY_WIDTH-1:0] mem [CAPACITY+1];
  logic                 mem_we;
  logic [AddrW-1:0]     mem_waddr, mem_raddr;
  logic [KEY_WIDTH-1:0] mem_wdata, rd_q;

  logic                 order_mode_q;
  logic [AddrW-1:0]     cnt_q, cnt_d, pos_q, pos_d, cidx_q, cidx_d;
  logic [KEY_WIDTH-1:0] k_q, k_d, c_q, c_d, taken_q, taken_d;
  bhpq_pkg::status_e    status_q, status_d;

  logic                 out_valid_q, out_valid_d;
  logic [31:0]          out_key_q, out_key_d;
  logic [7:0]           out_count_q, out_count_d;
  bhpq_pkg::status_e    out_status_q, out_status_d;

  logic [63:0]          key_ext, taken_ext;
  logic [KEY_WIDTH-1:0] key_in;
  logic [AddrW:0]       child, child_nx;
  logic [AddrW:0]       cnt_x;
  logic [AddrW-1:0]     parent;
  logic [15:0]          cnt_wide;
  logic                 accept, out_free, up_win, sib_win, dn_win;
  logic                 is_full, is_empty, has_parent, key_match;
  bhpq_pkg::func_e      func;

  assign func       = bhpq_pkg::func_e'(s_axis_tuser);
  assign key_ext    = 64'($signed(s_axis_tdata));
  assign key_in     = key_ext[KEY_WIDTH-1:0];
  assign taken_ext  = 64'($signed(taken_q));
  assign cnt_wide   = 16'(cnt_q);
  assign cnt_x      = {1'b0, cnt_q};
  assign child      = {pos_q, 1'b0};
  assign child_nx   = child + (AddrW+1)'(1);
  assign parent     = pos_q >> 1;
  assign has_parent = pos_q > AddrW'(1);
  assign is_full    = cnt_q >= AddrW'(CAPACITY);
  assign is_empty   = cnt_q == '0;
  assign key_match  = rd_q == k_q;
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_valid_q || m_axis_tready;

  assign up_win  = bhpq_pkg::ranks_above(64'($signed(k_q)), 64'($signed(rd_q)), order_mode_q);
  assign sib_win = bhpq_pkg::ranks_above(64'($signed(rd_q)), 64'($signed(c_q)), order_mode_q);
  assign dn_win  = bhpq_pkg::ranks_above(64'($signed(c_q)), 64'($signed(k_q)), order_mode_q);

  assign s_axis_tready = state_q == bhpq_pkg::ST_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_count_q, out_key_q};
  assign m_axis_tuser  = out_status_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bhpq_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (func)
            bhpq_pkg::FUNC_INSERT:  state_d = is_full ? bhpq_pkg::ST_DONE : bhpq_pkg::ST_SU_RD;
            bhpq_pkg::FUNC_DEL_TOP: state_d = is_empty ? bhpq_pkg::ST_DONE : bhpq_pkg::ST_DT_RD;
            bhpq_pkg::FUNC_DEL_KEY: state_d = is_empty ? bhpq_pkg::ST_DONE : bhpq_pkg::ST_SR_RD;
            default:                state_d = bhpq_pkg::ST_DONE;
          endcase
        end
      end
      bhpq_pkg::ST_SU_RD:   state_d = has_parent ? bhpq_pkg::ST_SU_CMP : bhpq_pkg::ST_DONE;
      bhpq_pkg::ST_SU_CMP:  state_d = up_win ? bhpq_pkg::ST_SU_RD : bhpq_pkg::ST_DONE;
      bhpq_pkg::ST_DT_RD:   state_d = bhpq_pkg::ST_DT_TAKE;
      bhpq_pkg::ST_DT_TAKE: state_d = bhpq_pkg::ST_RM_LAST;
      bhpq_pkg::ST_SR_RD:   state_d = bhpq_pkg::ST_SR_CMP;
      bhpq_pkg::ST_SR_CMP: begin
        if (key_match) begin
          state_d = bhpq_pkg::ST_RM_LAST;
        end else if (pos_q == cnt_q) begin
          state_d = bhpq_pkg::ST_DONE;
        end else begin
          state_d = bhpq_pkg::ST_SR_RD;
        end
      end
      bhpq_pkg::ST_RM_LAST: state_d = bhpq_pkg::ST_RM_LASTD;
      bhpq_pkg::ST_RM_LASTD: begin
        if (pos_q > cnt_q) begin
          state_d = bhpq_pkg::ST_DONE;
        end else if (has_parent) begin
          state_d = bhpq_pkg::ST_RM_PAR;
        end else begin
          state_d = bhpq_pkg::ST_SD_RD;
        end
      end
      bhpq_pkg::ST_RM_PAR:  state_d = up_win ? bhpq_pkg::ST_SU_RD : bhpq_pkg::ST_SD_RD;
      bhpq_pkg::ST_SD_RD:   state_d = (child > cnt_x) ? bhpq_pkg::ST_DONE : bhpq_pkg::ST_SD_C1;
      bhpq_pkg::ST_SD_C1:   state_d = (child < cnt_x) ? bhpq_pkg::ST_SD_C2 : bhpq_pkg::ST_SD_DEC;
      bhpq_pkg::ST_SD_C2:   state_d = bhpq_pkg::ST_SD_DEC;
      bhpq_pkg::ST_SD_DEC:  state_d = dn_win ? bhpq_pkg::ST_SD_RD : bhpq_pkg::ST_DONE;
      bhpq_pkg::ST_DONE:    state_d = out_free ? bhpq_pkg::ST_IDLE : bhpq_pkg::ST_DONE;
      default:              state_d = bhpq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = pos_q;
    mem_wdata    = k_q;
    mem_raddr    = '0;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    cidx_d       = cidx_q;
    k_d          = k_q;
    c_d          = c_q;
    taken_d      = taken_q;
    status_d     = status_q;
    out_valid_d  = m_axis_tready ? 1'b0 : out_valid_q;
    out_key_d    = out_key_q;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;
    unique case (state_q) inside
      bhpq_pkg::ST_IDLE: begin
        if (accept) begin
          k_d      = key_in;
          taken_d  = '0;
          status_d = bhpq_pkg::STAT_OK;
          pos_d    = AddrW'(1);
          unique case (func) inside
            bhpq_pkg::FUNC_INSERT: begin
              if (is_full) begin
                status_d = bhpq_pkg::STAT_FULL;
              end else begin
                cnt_d = cnt_q + AddrW'(1);
                pos_d = cnt_q + AddrW'(1);
              end
            end
            bhpq_pkg::FUNC_DEL_TOP, bhpq_pkg::FUNC_DEL_KEY: begin
              if (is_empty) begin
                status_d = bhpq_pkg::STAT_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      bhpq_pkg::ST_SU_RD: begin
        if (has_parent) begin
          mem_raddr = parent;
        end else begin
          mem_we = 1'b1;
        end
      end
      bhpq_pkg::ST_SU_CMP, bhpq_pkg::ST_RM_PAR: begin
        if (up_win) begin
          mem_we    = 1'b1;
          mem_wdata = rd_q;
          pos_d     = parent;
        end else if (state_q == bhpq_pkg::ST_SU_CMP) begin
          mem_we = 1'b1;
        end
      end
      bhpq_pkg::ST_DT_RD: mem_raddr = AddrW'(1);
      bhpq_pkg::ST_DT_TAKE: taken_d = rd_q;
      bhpq_pkg::ST_SR_RD: mem_raddr = pos_q;
      bhpq_pkg::ST_SR_CMP: begin
        if (key_match) begin
          taken_d = rd_q;
        end else if (pos_q == cnt_q) begin
          status_d = bhpq_pkg::STAT_NOT_FOUND;
        end else begin
          pos_d = pos_q + AddrW'(1);
        end
      end
      bhpq_pkg::ST_RM_LAST: begin
        mem_raddr = cnt_q;
        cnt_d     = cnt_q - AddrW'(1);
      end
      bhpq_pkg::ST_RM_LASTD: begin
        k_d       = rd_q;
        mem_raddr = parent;
      end
      bhpq_pkg::ST_SD_RD: begin
        if (child > cnt_x) begin
          mem_we = 1'b1;
        end else begin
          mem_raddr = child[AddrW-1:0];
        end
      end
      bhpq_pkg::ST_SD_C1: begin
        c_d       = rd_q;
        cidx_d    = child[AddrW-1:0];
        mem_raddr = child_nx[AddrW-1:0];
      end
      bhpq_pkg::ST_SD_C2: begin
        if (sib_win) begin
          c_d    = rd_q;
          cidx_d = child_nx[AddrW-1:0];
        end
      end
      bhpq_pkg::ST_SD_DEC: begin
        mem_we = 1'b1;
        if (dn_win) begin
          mem_wdata = c_q;
          pos_d     = cidx_q;
        end
      end
      bhpq_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_key_d    = taken_ext[31:0];
          out_count_d  = cnt_wide[7:0];
          out_status_d = status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bhpq_pkg::ST_IDLE;
      cnt_q        <= '0;
      order_mode_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        order_mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    cidx_q       <= cidx_d;
    k_q          <= k_d;
    c_q          <= c_d;
    taken_q      <= taken_d;
    status_q     <= status_d;
    out_key_q    <= out_key_d;
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary heap priority queue.
// ----------------------------------------------------------------------------
// A directed table covers empty and not-found errors, the unused operation,
// the key extremes and an order change with keys held. Random traffic then
// fills the heap to capacity, drains it past empty and mixes all operations.
// Both stream sides idle at random, and the receiver holds off for a long
// stretch once. Every result item is compared field by field against a heap
// model kept in the bench, or against a value typed into the table.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CAP          = bhpq_pkg::CapacityDef;
  localparam int unsigned LIMIT_CYCLES = 4_000_000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned NUM_ROWS     = 26;

  typedef struct packed {
    logic [31:0]       key;
    bhpq_pkg::status_e stat;
    logic [7:0]        cnt;
  } heap_res_t;

  typedef struct {
    bit                wr_cfg;
    bit                cfg_val;
    bhpq_pkg::func_e   func;
    logic [31:0]       key;
    bit                typed;
    logic [31:0]       t_key;
    bhpq_pkg::status_e t_stat;
    logic [7:0]        t_cnt;
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  logic signed [31:0] heap_keys [0:CAP];
  int unsigned        held;
  bit                 max_top;
  int unsigned        full_hits;
  int unsigned        empty_hits;

  heap_res_t   pending_results[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned cycles;
  int unsigned tx_idle;
  int unsigned rx_idle;
  int unsigned stall_left;
  bit          hold_request;

  plan_row_t plan [NUM_ROWS] = '{
    '{0, 0, bhpq_pkg::FUNC_DEL_TOP, 32'h0000_0000, 1, 32'h0, bhpq_pkg::STAT_EMPTY, 8'd0},
    '{0, 0, bhpq_pkg::FUNC_DEL_KEY, 32'h0000_0005, 1, 32'h0, bhpq_pkg::STAT_EMPTY, 8'd0},
    '{0, 0, bhpq_pkg::FUNC_NONE,    32'hFFFF_FFFF, 1, 32'h0, bhpq_pkg::STAT_OK,    8'd0},
    '{0, 0, bhpq_pkg::FUNC_INSERT,  32'h7FFF_FFFF, 1, 32'h0, bhpq_pkg::STAT_OK,    8'd1},
    '{0, 0, bhpq_pkg::FUNC_INSERT,  32'h8000_0000, 1, 32'h0, bhpq_pkg::STAT_OK,    8'd2},
    '{0, 0, bhpq_pkg::FUNC_INSERT,  32'h0000_0000, 1, 32'h0, bhpq_pkg::STAT_OK,    8'd3},
    '{0, 0, bhpq_pkg::FUNC_INSERT,  32'hFFFF_FFFF, 0, 32'h0, bhpq_pkg::STAT_OK,    8'd0},
    '{0, 0, bhpq_pkg::FUNC_DEL_KEY, 32'h0000_3039, 1, 32'h0, bhpq_pkg::STAT_NOT_FOUND, 8'd4},
    '{0, 0, bhpq_pkg::FUNC_DEL_TOP, 32'h0000_0000, 1, 32'h8000_0000, bhpq_pkg::STAT_OK, 8'd3},
    '{1, 1, bhpq_pkg::FUNC_NONE,    32'h0000_0000, 0, 32'h0, bhpq_pkg::STAT_OK,    8'd0},
    '{0, 0, bhpq_pkg::FUNC_DEL_TOP, 32'h0000_0000, 0, 32'h0, bhpq_pkg::STAT_OK,    8'd0},
    '{0, 0, bhpq_pkg::FUNC_INSERT,  32'h7FFF_FFFF, 0, 32'h0, bhpq_pkg::STAT_OK,    8'd0},
    '{0, 0, bhpq_pkg::FUNC_INSERT,  32'h8000_0000, 0, 32'h0, bhpq_pkg::STAT_OK,    8'd0},
    '{0, 0, bhpq_pkg::FUNC_DEL_KEY, 32'h7FFF_FFFF, 0, 32'h0, bhpq_pkg::STAT_OK,    8'd0},
    '{0, 0, bhpq_pkg::FUNC_NONE,    32'h1234_5678, 0, 32'h0, bhpq_pkg::STAT_OK,    8'd0},
    '{0, 0, bhpq_pkg::FUNC_DEL_KEY, 32'h0000_0000, 0, 32'h0, bhpq_pkg::STAT_OK,    8'd0},
    '{0, 0, bhpq_pkg::FUNC_DEL_TOP, 32'h0000_0000, 0, 32'h0, bhpq_pkg::STAT_OK,    8'd0},
    '{0, 0, bhpq_pkg::FUNC_DEL_TOP, 32'h0000_0000, 0, 32'h0, bhpq_pkg::STAT_OK,    8'd0},
    '{0, 0, bhpq_pkg::FUNC_DEL_TOP, 32'h0000_0000, 0, 32'h0, bhpq_pkg::STAT_OK,    8'd0},
    '{0, 0, bhpq_pkg::FUNC_DEL_TOP, 32'h0000_0000, 0, 32'h0, bhpq_pkg::STAT_OK,    8'd0},
    '{1, 0, bhpq_pkg::FUNC_NONE,    32'h0000_0000, 0, 32'h0, bhpq_pkg::STAT_OK,    8'd0},
    '{0, 0, bhpq_pkg::FUNC_INSERT,  32'h0000_0005, 0, 32'h0, bhpq_pkg::STAT_OK,    8'd0},
    '{0, 0, bhpq_pkg::FUNC_INSERT,  32'h0000_0005, 0, 32'h0, bhpq_pkg::STAT_OK,    8'd0},
    '{0, 0, bhpq_pkg::FUNC_DEL_KEY, 32'h0000_0005, 0, 32'h0, bhpq_pkg::STAT_OK,    8'd0},
    '{0, 0, bhpq_pkg::FUNC_DEL_KEY, 32'h0000_0005, 0, 32'h0, bhpq_pkg::STAT_OK,    8'd0},
    '{0, 0, bhpq_pkg::FUNC_DEL_KEY, 32'h0000_0005, 1, 32'h0, bhpq_pkg::STAT_EMPTY, 8'd0}
  };

  binary_heap_priority_queue dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit outranks(logic signed [31:0] a, logic signed [31:0] b);
    return max_top ? (a > b) : (a < b);
  endfunction

  function automatic void bubble_up(int unsigned pos, logic signed [31:0] k);
    while (pos > 1 && outranks(k, heap_keys[pos / 2])) begin
      heap_keys[pos] = heap_keys[pos / 2];
      pos = pos / 2;
    end
    heap_keys[pos] = k;
  endfunction

  function automatic void bubble_down(int unsigned pos, logic signed [31:0] k);
    int unsigned child;
    child = pos * 2;
    while (child <= held) begin
      if (child < held && outranks(heap_keys[child + 1], heap_keys[child])) child++;
      if (!outranks(heap_keys[child], k)) break;
      heap_keys[pos] = heap_keys[child];
      pos = child;
      child = pos * 2;
    end
    heap_keys[pos] = k;
  endfunction

  function automatic logic signed [31:0] extract_at(int unsigned pos);
    logic signed [31:0] taken;
    logic signed [31:0] last_k;
    taken = heap_keys[pos];
    last_k = heap_keys[held];
    held--;
    if (pos <= held) begin
      if (pos > 1 && outranks(last_k, heap_keys[pos / 2])) bubble_up(pos, last_k);
      else bubble_down(pos, last_k);
    end
    return taken;
  endfunction

  function automatic heap_res_t heap_apply(bhpq_pkg::func_e f, logic signed [31:0] k);
    heap_res_t   r;
    int unsigned slot;
    r.key = '0;
    r.stat = bhpq_pkg::STAT_OK;
    slot = 0;
    case (f)
      bhpq_pkg::FUNC_INSERT: begin
        if (held >= CAP) r.stat = bhpq_pkg::STAT_FULL;
        else begin
          held++;
          bubble_up(held, k);
        end
      end
      bhpq_pkg::FUNC_DEL_TOP: begin
        if (held == 0) r.stat = bhpq_pkg::STAT_EMPTY;
        else r.key = extract_at(1);
      end
      bhpq_pkg::FUNC_DEL_KEY: begin
        if (held == 0) r.stat = bhpq_pkg::STAT_EMPTY;
        else begin
          for (int unsigned i = 1; i <= held && slot == 0; i++)
            if (heap_keys[i] == k) slot = i;
          if (slot == 0) r.stat = bhpq_pkg::STAT_NOT_FOUND;
          else r.key = extract_at(slot);
        end
      end
      default: ;
    endcase
    if (r.stat == bhpq_pkg::STAT_FULL) full_hits++;
    if (r.stat == bhpq_pkg::STAT_EMPTY) empty_hits++;
    r.cnt = held[7:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 7)) inside
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3: return 32'($urandom_range(0, 40)) - 32'd20;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_victim();
    if (held != 0 && $urandom_range(0, 3) != 0) return heap_keys[$urandom_range(1, held)];
    return pick_key();
  endfunction

  task automatic drive_op(input bhpq_pkg::func_e f, input logic [31:0] k, input bit typed,
                          input heap_res_t want);
    heap_res_t got;
    while ($urandom_range(0, 99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= k;
    do @(posedge clk_i); while (!s_axis_tready);
    got = heap_apply(f, k);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0 || !s_axis_tready);
  endtask

  task automatic set_order(input bit v);
    wait_quiet();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    max_top = v;
  endtask

  task automatic random_item(input int unsigned ins_w, input int unsigned top_w,
                             input int unsigned key_w, input int unsigned none_w);
    int unsigned     roll;
    bhpq_pkg::func_e f;
    logic [31:0]     k;
    roll = $urandom_range(0, ins_w + top_w + key_w + none_w - 1);
    if (roll < ins_w) begin
      f = bhpq_pkg::FUNC_INSERT;
      k = pick_key();
    end else if (roll < ins_w + top_w) begin
      f = bhpq_pkg::FUNC_DEL_TOP;
      k = $urandom();
    end else if (roll < ins_w + top_w + key_w) begin
      f = bhpq_pkg::FUNC_DEL_KEY;
      k = pick_victim();
    end else begin
      f = bhpq_pkg::FUNC_NONE;
      k = $urandom();
    end
    drive_op(f, k, 1'b0, '0);
  endtask

  initial begin
    while (cycles < LIMIT_CYCLES) @(posedge clk_i) cycles++;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    heap_res_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d: key %h status %0d count %0d", results_seen,
                   m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[39:32]);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== exp_r.key || m_axis_tuser !== exp_r.stat ||
            m_axis_tdata[39:32] !== exp_r.cnt) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("mismatch on result %0d: expected key %h status %0d count %0d,",
                   results_seen, exp_r.key, exp_r.stat, exp_r.cnt);
            $display(" got key %h status %0d count %0d",
                     m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[39:32]);
          end
        end
      end
    end
  end

  initial begin
    heap_res_t want;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= bhpq_pkg::FUNC_INSERT;
    m_axis_tready <= 1'b0;
    held = 0;
    max_top = 1'b0;
    full_hits = 0;
    empty_hits = 0;
    mismatches = 0;
    results_seen = 0;
    cycles = 0;
    stall_left = 0;
    hold_request = 1'b0;
    tx_idle = 21;
    rx_idle = 76;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].wr_cfg) set_order(plan[i].cfg_val);
      else begin
        want.key  = plan[i].t_key;
        want.stat = plan[i].t_stat;
        want.cnt  = plan[i].t_cnt;
        drive_op(plan[i].func, plan[i].key, plan[i].typed, want);
      end
    end

    // fill to capacity, then mix in max order
    set_order(1'b0);
    full_hits = 0;
    while (full_hits < 4) random_item(92, 3, 3, 2);
    set_order(1'b1);
    repeat (100) random_item(40, 25, 30, 5);

    // swap idle rates, hold off the receiver, then drain past empty
    tx_idle = 76;
    rx_idle = 21;
    hold_request = 1'b1;
    repeat (100) random_item(40, 25, 30, 5);
    set_order(1'b0);
    empty_hits = 0;
    while (empty_hits < 4) random_item(8, 46, 44, 2);

    // full rate on both sides
    tx_idle = 0;
    rx_idle = 0;
    set_order(1'b1);
    repeat (60) random_item(60, 15, 20, 5);
    wait_quiet();
    repeat (60) random_item(35, 30, 30, 5);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bhpq_pkg.sv
hdl/binary_heap_priority_queue.sv
bench/tb.sv
